>>> hw/rtl/svm_pkg.sv
// Shared types and constants for the sample voice mixer.
`default_nettype none
package svm_pkg;
    localparam int VOICES_DEF = 16;
    localparam int SOUNDS_DEF = 16;
    localparam int SAMPLE_WORDS_DEF = 524288;

    localparam logic [15:0] AMB_VOL_RST = 16'd13107;
    localparam logic [3:0]  AMB_SND_RST = 4'd5;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_PLAY   = 3'd1,
        MODE_AMB    = 3'd2,
        MODE_UPDATE = 3'd3,
        MODE_LOAD   = 3'd4,
        MODE_DEFINE = 3'd5,
        MODE_NOP6   = 3'd6,
        MODE_NOP7   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_AMB_VOL = 2'd1,
        REG_AMB_SND = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PLAY,
        ST_AMB,
        ST_UPDATE,
        ST_MIX_ADDR,
        ST_MIX_READ,
        ST_MIX_MUL,
        ST_MIX_ACC,
        ST_MIX_DONE,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_play;
        logic do_amb;
        logic do_update;
        logic do_load;
        logic do_define;
        logic mix_clear;
        logic mix_addr;
        logic mix_read;
        logic mix_mul;
        logic mix_acc;
        logic mix_next;
        logic mix_done;
    } svm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  last_voice;
    } svm_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/sample_voice_mixer.sv
// Top level of the sample voice mixer: register port, controller and datapath.
// Tick: voices are walked one by one through address, read, multiply and
// accumulate, set by the single shared sample-store read port and multiplier.
// Play, ambient, update act after dispatch; load and define act in dispatch.
// One item at a time; the result waits in an output register until taken.
// rst_n clears voices, sound table and registers at once; the sample store
// is not cleared and needs no clearing pass.
`default_nettype none
module sample_voice_mixer
#(
    parameter int VOICES       = svm_pkg::VOICES_DEF,
    parameter int SOUNDS       = svm_pkg::SOUNDS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        mode,
    input  wire logic [3:0]        sound_num,
    input  wire logic [15:0]       volume,
    input  wire logic              ambient_on,
    input  wire logic [18:0]       sample_address,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [18:0]       sound_start,
    input  wire logic [19:0]       sound_length,
    input  wire logic              sound_loops,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   result_kind,
    output logic signed [15:0]     mixed_sample,
    output logic                   voice_granted,
    output logic [3:0]             voice_index
);
    import svm_pkg::*;

    logic        enable_reg;
    logic [15:0] amb_vol_reg;
    logic [3:0]  amb_snd_reg;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            amb_vol_reg <= AMB_VOL_RST;
            amb_snd_reg <= AMB_SND_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_ENABLE:  enable_reg <= pwdata[0];
                REG_AMB_VOL: amb_vol_reg <= pwdata[15:0];
                REG_AMB_SND: amb_snd_reg <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            REG_AMB_VOL: prdata = {16'd0, amb_vol_reg};
            REG_AMB_SND: prdata = {28'd0, amb_snd_reg};
            default:     prdata = '0;
        endcase
    end

    svm_cmd_t cmd;
    svm_sts_t sts;

    svm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    svm_dp #(
        .VOICES       (VOICES),
        .SOUNDS       (SOUNDS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .sound_num      (sound_num),
        .volume         (volume),
        .ambient_on     (ambient_on),
        .sample_address (sample_address),
        .sample_value   (sample_value),
        .sound_start    (sound_start),
        .sound_length   (sound_length),
        .sound_loops    (sound_loops),
        .cfg_enable     (enable_reg),
        .cfg_amb_vol    (amb_vol_reg),
        .cfg_amb_snd    (amb_snd_reg),
        .result_kind    (result_kind),
        .mixed_sample   (mixed_sample),
        .voice_granted  (voice_granted),
        .voice_index    (voice_index)
    );
endmodule
`default_nettype wire

>>> hw/rtl/svm_ctrl.sv
// Controller state machine for the sample voice mixer.
`default_nettype none
module svm_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire svm_pkg::svm_sts_t sts,
    output svm_pkg::svm_cmd_t    cmd
);
    import svm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_TICK:
                    begin
                        cmd.mix_clear = 1'b1;
                        state_next = ST_MIX_ADDR;
                    end
                    MODE_PLAY:   state_next = ST_PLAY;
                    MODE_AMB:    state_next = ST_AMB;
                    MODE_UPDATE: state_next = ST_UPDATE;
                    MODE_LOAD:
                    begin
                        cmd.do_load = 1'b1;
                        state_next = ST_IDLE;
                    end
                    MODE_DEFINE:
                    begin
                        cmd.do_define = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PLAY:
            begin
                cmd.do_play = 1'b1;
                state_next = ST_OUT;
            end
            ST_AMB:
            begin
                cmd.do_amb = 1'b1;
                state_next = ST_IDLE;
            end
            ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MIX_ADDR:
            begin
                cmd.mix_addr = 1'b1;
                state_next = ST_MIX_READ;
            end
            ST_MIX_READ:
            begin
                cmd.mix_read = 1'b1;
                state_next = ST_MIX_MUL;
            end
            ST_MIX_MUL:
            begin
                cmd.mix_mul = 1'b1;
                state_next = ST_MIX_ACC;
            end
            ST_MIX_ACC:
            begin
                cmd.mix_acc = 1'b1;
                cmd.mix_next = 1'b1;
                state_next = sts.last_voice ? ST_MIX_DONE : ST_MIX_ADDR;
            end
            ST_MIX_DONE:
            begin
                cmd.mix_done = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/svm_dp.sv
// Datapath for the sample voice mixer: voices, sound table, sample store, mix.
`default_nettype none
module svm_dp
#(
    parameter int VOICES       = svm_pkg::VOICES_DEF,
    parameter int SOUNDS       = svm_pkg::SOUNDS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire svm_pkg::svm_cmd_t cmd,
    output svm_pkg::svm_sts_t      sts,
    input  wire logic [2:0]        mode,
    input  wire logic [3:0]        sound_num,
    input  wire logic [15:0]       volume,
    input  wire logic              ambient_on,
    input  wire logic [18:0]       sample_address,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [18:0]       sound_start,
    input  wire logic [19:0]       sound_length,
    input  wire logic              sound_loops,
    input  wire logic              cfg_enable,
    input  wire logic [15:0]       cfg_amb_vol,
    input  wire logic [3:0]        cfg_amb_snd,
    output logic                   result_kind,
    output logic signed [15:0]     mixed_sample,
    output logic                   voice_granted,
    output logic [3:0]             voice_index
);
    import svm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_WORDS_DEF);
    localparam int SW = 4;
    localparam int ACC_W = 33 + VW + 1;

    // Captured item
    mode_t             mode_reg;
    logic [3:0]        snd_reg;
    logic [15:0]       vol_reg;
    logic              amb_on_reg;
    logic [18:0]       saddr_reg;
    logic signed [15:0] sval_reg;
    logic [18:0]       sstart_reg;
    logic [19:0]       slen_reg;
    logic              sloops_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg   <= mode_t'(mode);
            snd_reg    <= sound_num;
            vol_reg    <= volume;
            amb_on_reg <= ambient_on;
            saddr_reg  <= sample_address;
            sval_reg   <= sample_value;
            sstart_reg <= sound_start;
            slen_reg   <= sound_length;
            sloops_reg <= sound_loops;
        end
    end

    // Voice and sound state
    logic [VOICES-1:0] act_reg, loops_reg;
    logic [SW-1:0]     vsnd_reg  [VOICES];
    logic [19:0]       vpos_reg  [VOICES];
    logic [15:0]       vgain_reg [VOICES];
    logic [18:0]       tstart_reg [SOUNDS];
    logic [19:0]       tlen_reg   [SOUNDS];
    logic [SOUNDS-1:0] tloops_reg;
    logic              amb_want_reg, amb_valid_reg;
    logic [VW-1:0]     amb_slot_reg;

    // Sound lookup helpers
    function automatic logic [19:0] len_of(input logic [3:0] s,
                                           input logic [19:0] tl [SOUNDS]);
        logic [19:0] r;
        r = '0;
        for (int i = 0; i < SOUNDS; i++)
        begin
            if (int'(s) == i)
            begin
                r = tl[i];
            end
        end
        return r;
    endfunction

    // First free and first non-looping voice
    logic          free_found, steal_found;
    logic [VW-1:0] free_idx, steal_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        steal_found = 1'b0;
        steal_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_found = 1'b1;
                free_idx = VW'(i);
            end
            if (!loops_reg[i])
            begin
                steal_found = 1'b1;
                steal_idx = VW'(i);
            end
        end
    end

    logic snd_loop_flag;
    always_comb
    begin
        snd_loop_flag = 1'b0;
        for (int i = 0; i < SOUNDS; i++)
        begin
            if (int'(snd_reg) == i)
            begin
                snd_loop_flag = tloops_reg[i];
            end
        end
    end

    // Ambient start needed by ambient set or update
    logic amb_slot_lost;
    assign amb_slot_lost = !act_reg[amb_slot_reg];
    logic amb_start;
    always_comb
    begin
        amb_start = 1'b0;
        if (cmd.do_amb && amb_on_reg && !amb_valid_reg)
        begin
            amb_start = 1'b1;
        end
        if (cmd.do_update && amb_want_reg && amb_valid_reg && amb_slot_lost)
        begin
            amb_start = 1'b1;
        end
    end

    // Mix walk
    logic [VW-1:0]       vi_reg;
    logic                hit_reg;
    logic [AW-1:0]       raddr_reg;
    logic signed [15:0]  rdata_reg;
    logic signed [32:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]         gain_reg;
    logic signed [15:0]  store [SAMPLE_WORDS_DEF];

    logic [19:0] cur_len, cur_pos, use_pos;
    logic [18:0] cur_start;
    logic        cur_act, cur_end, cur_play;
    always_comb
    begin
        cur_len = len_of(vsnd_reg[vi_reg], tlen_reg);
        cur_start = '0;
        for (int i = 0; i < SOUNDS; i++)
        begin
            if (int'(vsnd_reg[vi_reg]) == i)
            begin
                cur_start = tstart_reg[i];
            end
        end
        cur_pos = vpos_reg[vi_reg];
        cur_act = act_reg[vi_reg];
        cur_end = (cur_pos >= cur_len);
        cur_play = cur_act && (cur_len != 20'd0) && (!cur_end || loops_reg[vi_reg]);
        use_pos = cur_end ? 20'd0 : cur_pos;
    end

    logic [20:0] addr_sum;
    assign addr_sum = 21'(cur_start) + 21'(use_pos);
    assign sts.mode = mode_reg;
    assign sts.last_voice = (vi_reg == VW'(VOICES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.do_load)
        begin
            store[AW'(saddr_reg)] <= sval_reg;
        end
        if (cmd.mix_read)
        begin
            rdata_reg <= store[raddr_reg];
        end
        if (cmd.mix_addr)
        begin
            raddr_reg <= AW'(addr_sum);
            gain_reg  <= vgain_reg[vi_reg];
        end
        if (cmd.mix_mul)
        begin
            prod_reg <= hit_reg ? (rdata_reg * $signed({1'b0, gain_reg})) : 33'sd0;
        end
    end

    // Rounded and clipped mix
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-16:0] q;
    logic signed [15:0] clip;
    always_comb
    begin
        rnd = acc_reg + ACC_W'(16384);
        q = rnd[ACC_W-1:15];
        if (q > 32767)
        begin
            clip = 16'sh7fff;
        end
        else if (q < -32768)
        begin
            clip = 16'sh8000;
        end
        else
        begin
            clip = q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            loops_reg <= '0;
            tloops_reg <= '0;
            amb_want_reg <= 1'b0;
            amb_valid_reg <= 1'b0;
            amb_slot_reg <= '0;
            vi_reg <= '0;
            hit_reg <= 1'b0;
            acc_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                vsnd_reg[i] <= '0;
                vpos_reg[i] <= '0;
                vgain_reg[i] <= '0;
            end
            for (int i = 0; i < SOUNDS; i++)
            begin
                tstart_reg[i] <= '0;
                tlen_reg[i] <= '0;
            end
            result_kind <= 1'b0;
            mixed_sample <= '0;
            voice_granted <= 1'b0;
            voice_index <= '0;
        end
        else
        begin
            if (cmd.do_define)
            begin
                for (int i = 0; i < SOUNDS; i++)
                begin
                    if (int'(snd_reg) == i)
                    begin
                        tstart_reg[i] <= sstart_reg;
                        tlen_reg[i] <= slen_reg;
                        tloops_reg[i] <= sloops_reg;
                    end
                end
            end
            if (cmd.do_play)
            begin
                result_kind <= 1'b1;
                mixed_sample <= '0;
                voice_granted <= 1'b0;
                voice_index <= '0;
                if (cfg_enable && (free_found || steal_found))
                begin
                    voice_granted <= 1'b1;
                    voice_index <= 4'(free_found ? free_idx : steal_idx);
                    vsnd_reg[free_found ? free_idx : steal_idx] <= snd_reg;
                    vpos_reg[free_found ? free_idx : steal_idx] <= '0;
                    vgain_reg[free_found ? free_idx : steal_idx] <= vol_reg;
                    act_reg[free_found ? free_idx : steal_idx] <= 1'b1;
                    loops_reg[free_found ? free_idx : steal_idx] <=
                        free_found ? snd_loop_flag : 1'b0;
                end
            end
            if (cmd.do_amb)
            begin
                amb_want_reg <= amb_on_reg;
                if (!amb_on_reg && amb_valid_reg)
                begin
                    act_reg[amb_slot_reg] <= 1'b0;
                    amb_valid_reg <= 1'b0;
                end
            end
            if (cmd.do_update && amb_want_reg && amb_valid_reg && amb_slot_lost)
            begin
                amb_valid_reg <= 1'b0;
            end
            if (amb_start && free_found)
            begin
                vsnd_reg[free_idx] <= cfg_amb_snd;
                vpos_reg[free_idx] <= '0;
                vgain_reg[free_idx] <= cfg_amb_vol;
                act_reg[free_idx] <= 1'b1;
                loops_reg[free_idx] <= 1'b1;
                amb_slot_reg <= free_idx;
                amb_valid_reg <= 1'b1;
            end
            if (cmd.mix_clear)
            begin
                acc_reg <= '0;
                vi_reg <= '0;
            end
            if (cmd.mix_addr)
            begin
                hit_reg <= cur_play;
                if (cur_act && !cur_play)
                begin
                    act_reg[vi_reg] <= 1'b0;
                end
                if (cur_play)
                begin
                    vpos_reg[vi_reg] <= use_pos + 20'd1;
                end
            end
            if (cmd.mix_acc)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (cmd.mix_next)
            begin
                vi_reg <= sts.last_voice ? '0 : vi_reg + VW'(1);
            end
            if (cmd.mix_done)
            begin
                result_kind <= 1'b0;
                mixed_sample <= clip;
                voice_granted <= 1'b0;
                voice_index <= '0;
            end
        end
    end
endmodule
`default_nettype wire
